### rtl/core/pmc_pkg.sv
// pmc_pkg: shared constants, types and the CORDIC angle table for the
// pose motion classifier. No dependencies.
`default_nettype none
package pmc_pkg;
  localparam int CordicStepsDef = 16;
  localparam int TableLen = 24;
  localparam logic signed [16:0] PiQ13 = 17'sd25736;
  localparam logic [17:0] BackLo = 18'd15441;
  localparam logic [17:0] BackHi = 18'd36031;

  localparam logic [15:0] DistResetVal = 16'd328;
  localparam logic [14:0] TurnResetVal = 15'd143;
  localparam logic [15:0] FactResetVal = 16'd4096;

  localparam logic [1:0] RegDist = 2'd0;
  localparam logic [1:0] RegTurn = 2'd1;
  localparam logic [1:0] RegFact = 2'd2;

  typedef enum logic [2:0] {
    MOT_FWD   = 3'd0,
    MOT_BACK  = 3'd1,
    MOT_LEFT  = 3'd2,
    MOT_RIGHT = 3'd3,
    MOT_STOP  = 3'd4
  } motion_t;

  // Front-to-back queue entry: label already known, or atan2 still needed.
  typedef struct packed {
    logic              need_atan;
    motion_t           motion;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] hp;
    logic              far;   // dsq > lim_sq
  } job_t;

  function automatic logic [13:0] atan_tab(input logic [4:0] i);
    logic [13:0] v;
    begin
      case (i)
        5'd0: v = 14'd6434;
        5'd1: v = 14'd3798;
        5'd2: v = 14'd2007;
        5'd3: v = 14'd1019;
        5'd4: v = 14'd511;
        5'd5: v = 14'd256;
        5'd6: v = 14'd128;
        5'd7: v = 14'd64;
        5'd8: v = 14'd32;
        5'd9: v = 14'd16;
        5'd10: v = 14'd8;
        5'd11: v = 14'd4;
        5'd12: v = 14'd2;
        5'd13: v = 14'd1;
        default: v = 14'd0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

### rtl/core/pmc_front.sv
// pmc_front: accepts pose samples, computes travel and heading change and
// decides turn/stop, pushing jobs into the queue. Uses pmc_pkg.
`default_nettype none
module pmc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [15:0] in_heading,
  input  wire logic [15:0]        dist_lim,
  input  wire logic [14:0]        turn_lim,
  input  wire logic [15:0]        turn_fact,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output pmc_pkg::job_t           job
);
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_SQX = 4'b0010, F_SQY = 4'b0100, F_DEC = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic have_prev_r;
  logic signed [31:0] prev_x_r, prev_y_r;
  logic signed [15:0] prev_h_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [15:0] hc_r, hp_r;
  logic [63:0] dsq_r;
  logic        sat_r;
  logic [63:0] lim_sq_r, turn_sq_r;
  logic [31:0] thr_r;
  logic [31:0] ax, ay, msel;
  logic [63:0] prod;
  logic signed [16:0] dh;
  logic [16:0] dang;
  logic [63:0] dsq_f;
  pmc_pkg::motion_t mot;
  logic turn_c, stop_c;

  assign in_ready = (state_r == F_IDLE);
  assign ax = dx_r[32] ? 32'(-dx_r) : dx_r[31:0];
  assign ay = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
  // Shared 32x32 multiplier for the squares of |dx| and |dy|.
  assign msel = (state_r == F_SQX) ? ax : ay;
  assign prod = {32'd0, msel} * {32'd0, msel};
  assign dsq_f = sat_r ? '1 : dsq_r;
  assign dh = 17'(hc_r) - 17'(hp_r);
  assign dang = dh[16] ? 17'(-dh) : 17'(dh);
  assign turn_c = (dang > {2'd0, turn_lim}) && (dsq_f < turn_sq_r);
  assign stop_c = dsq_f < lim_sq_r;
  always_comb begin
    if (hp_r < hc_r) mot = (hc_r == 16'sd0) ? pmc_pkg::MOT_RIGHT : pmc_pkg::MOT_LEFT;
    else mot = (hc_r == 16'sd0) ? pmc_pkg::MOT_LEFT : pmc_pkg::MOT_RIGHT;
    if (!turn_c) mot = pmc_pkg::MOT_STOP;
  end
  assign job_valid = (state_r == F_DEC);
  always_comb begin
    job.need_atan = !turn_c && !stop_c;
    job.motion = mot;
    job.dx = dx_r;
    job.dy = dy_r;
    job.hp = hp_r;
    job.far = dsq_f > lim_sq_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_SQX;
      F_SQX: state_nxt = F_SQY;
      F_SQY: state_nxt = F_DEC;
      F_DEC: if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      have_prev_r <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_h_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        have_prev_r <= 1'b1;
        prev_x_r <= in_pos_x;
        prev_y_r <= in_pos_y;
        prev_h_r <= in_heading;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        dx_r <= have_prev_r ? 33'(in_pos_x) - 33'(prev_x_r) : '0;
        dy_r <= have_prev_r ? 33'(in_pos_y) - 33'(prev_y_r) : '0;
        hc_r <= in_heading;
        hp_r <= have_prev_r ? prev_h_r : in_heading;
        lim_sq_r <= {32'd0, 16'd0, dist_lim} * {32'd0, 16'd0, dist_lim};
        thr_r <= 32'(({16'd0, turn_fact} * {16'd0, dist_lim}) >> 12);
      end
      F_SQX: begin
        sat_r <= (dx_r[32] ? (dx_r < -33'sd2147483647) : dx_r[31])
               | (dy_r[32] ? (dy_r < -33'sd2147483647) : dy_r[31]);
        dsq_r <= prod;
        turn_sq_r <= {32'd0, thr_r} * {32'd0, thr_r};
      end
      F_SQY: dsq_r <= dsq_r + prod;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/pmc_queue.sv
// pmc_queue: two-entry job queue between front and back parts.
// Uses pmc_pkg::job_t.
`default_nettype none
module pmc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire pmc_pkg::job_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output pmc_pkg::job_t      rd_data
);
  pmc_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### rtl/core/pmc_back.sv
// pmc_back: runs the CORDIC atan2 for jobs that need it and drives the
// result register. Uses pmc_pkg.
`default_nettype none
module pmc_back #(
  parameter int CORDIC_STEPS = pmc_pkg::CordicStepsDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire pmc_pkg::job_t job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_motion
);
  localparam int Steps = (CORDIC_STEPS < pmc_pkg::TableLen) ? CORDIC_STEPS
                                                             : pmc_pkg::TableLen;
  typedef enum logic [2:0] { B_IDLE = 3'b001, B_ITER = 3'b010, B_OUT = 3'b100 } bstate_t;

  bstate_t state_r;
  // 60 bits: |v| * 2^24 times the CORDIC gain stays below 2^59
  logic signed [59:0] x_r, y_r;
  logic signed [17:0] z_r;
  logic signed [15:0] hp_r;
  logic far_r;
  logic [4:0] i_r;
  logic [2:0] mot_r;
  logic signed [59:0] xs, ys, x0, y0;
  logic signed [17:0] at, dd;
  logic [17:0] dyaw;
  logic back;

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_motion = mot_r;
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = 18'(pmc_pkg::atan_tab(i_r));
  assign x0 = job.dx[32] ? 60'(-job.dx) <<< 24 : 60'(job.dx) <<< 24;
  assign y0 = job.dx[32] ? 60'(-job.dy) <<< 24 : 60'(job.dy) <<< 24;
  assign dd = z_r - 18'(hp_r);
  assign dyaw = dd[17] ? 18'(-dd) : 18'(dd);
  assign back = (dyaw > pmc_pkg::BackLo) && (dyaw < pmc_pkg::BackHi) && far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: if (job_valid) begin
          if (job.need_atan) state_r <= B_ITER;
          else state_r <= B_OUT;
        end
        B_ITER: if (i_r == 5'(Steps)) state_r <= B_OUT;
        B_OUT: if (out_ready) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        mot_r <= job.motion;
        x_r <= x0;
        y_r <= y0;
        z_r <= job.dx[32] ? (job.dy[32] ? -18'(pmc_pkg::PiQ13) : 18'(pmc_pkg::PiQ13)) : '0;
        hp_r <= job.hp;
        far_r <= job.far;
        i_r <= '0;
      end
      B_ITER: begin
        // in the cycle after the last step the angle is final: pick the label
        if (i_r == 5'(Steps)) begin
          mot_r <= back ? pmc_pkg::MOT_BACK : pmc_pkg::MOT_FWD;
        end else begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end else if (y_r < 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end
          i_r <= i_r + 5'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/pose_motion_classifier.sv
// pose_motion_classifier: top level, config registers, front, queue, back.
// Turn and stop samples bypass the CORDIC unit; moving samples wait for
// its atan2. The front takes a new sample only once its last job is in the
// queue, and the CORDIC unit sets the sustained rate for moving samples.
// Reset (rst_n, synchronous): registers to defaults, no previous sample.
`default_nettype none
module pose_motion_classifier #(
  parameter int CORDIC_STEPS = pmc_pkg::CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [15:0] in_heading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_motion,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  logic [15:0] dist_r, fact_r;
  logic [14:0] turn_r;
  logic fq_v, fq_r, qb_v, qb_r;
  pmc_pkg::job_t fq_d, qb_d;

  assign cfg_pready = 1'b1;
  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= pmc_pkg::DistResetVal;
      turn_r <= pmc_pkg::TurnResetVal;
      fact_r <= pmc_pkg::FactResetVal;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_paddr[3:2])
        pmc_pkg::RegDist: dist_r <= cfg_pwdata[15:0];
        pmc_pkg::RegTurn: turn_r <= cfg_pwdata[14:0];
        pmc_pkg::RegFact: fact_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      pmc_pkg::RegDist: cfg_prdata = {16'd0, dist_r};
      pmc_pkg::RegTurn: cfg_prdata = {17'd0, turn_r};
      pmc_pkg::RegFact: cfg_prdata = {16'd0, fact_r};
      default: cfg_prdata = '0;
    endcase
  end

  pmc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_heading,
    .dist_lim(dist_r), .turn_lim(turn_r), .turn_fact(fact_r),
    .job_valid(fq_v), .job_ready(fq_r), .job(fq_d)
  );
  pmc_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_v), .wr_ready(fq_r), .wr_data(fq_d),
    .rd_valid(qb_v), .rd_ready(qb_r), .rd_data(qb_d)
  );
  pmc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job_valid(qb_v), .job_ready(qb_r), .job(qb_d),
    .out_valid, .out_ready, .out_motion
  );
endmodule
`default_nettype wire

### test/pose_motion_classifier_test.sv
// Testbench for pose_motion_classifier: random and directed pose samples,
// APB register writes between phases, and a scoreboard of predicted labels.
// Depends on pmc_pkg and the RTL top level only.
`default_nettype none
module pose_motion_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Label predictor and store of pending labels
  class motion_board;
    bit [15:0] dist_lim;
    bit [14:0] turn_lim;
    bit [15:0] turn_fact;
    bit [31:0] last_x, last_y;
    bit [15:0] last_h;
    bit seen;
    pmc_pkg::motion_t pending[$];
    int errors;

    function void clear();
      dist_lim = pmc_pkg::DistResetVal;
      turn_lim = pmc_pkg::TurnResetVal;
      turn_fact = pmc_pkg::FactResetVal;
      last_x = 0;
      last_y = 0;
      last_h = 0;
      seen = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] v);
      if (idx == pmc_pkg::RegDist) dist_lim = v[15:0];
      else if (idx == pmc_pkg::RegTurn) turn_lim = v[14:0];
      else if (idx == pmc_pkg::RegFact) turn_fact = v[15:0];
    endfunction

    // vectoring CORDIC, result in Q3.13
    function int heading_of(longint sy, longint sx);
      longint vx, vy, hx, hy;
      int z;
      vx = sx;
      vy = sy;
      z = 0;
      if (vx < 0) begin
        z = (vy >= 0) ? 25736 : -25736;
        vx = -vx;
        vy = -vy;
      end
      vx = vx * (64'sd1 << 24);
      vy = vy * (64'sd1 << 24);
      for (int i = 0; i < pmc_pkg::CordicStepsDef && i < pmc_pkg::TableLen; i++) begin
        hx = vx >>> i;
        hy = vy >>> i;
        if (vy > 0) begin
          vx += hy;
          vy -= hx;
          z += int'(pmc_pkg::atan_tab(5'(i)));
        end else if (vy < 0) begin
          vx -= hy;
          vy += hx;
          z -= int'(pmc_pkg::atan_tab(5'(i)));
        end
      end
      return z;
    endfunction

    function void note_sample(bit [31:0] x, bit [31:0] y, bit [15:0] h);
      longint dx, dy, ax, ay;
      bit [63:0] dsq, lim_sq, thr, thr_sq;
      int hc, hp, dh, dd;
      pmc_pkg::motion_t m;
      bit [31:0] px, py;
      bit [15:0] ph;
      px = seen ? last_x : x;
      py = seen ? last_y : y;
      ph = seen ? last_h : h;
      dx = longint'($signed(x)) - longint'($signed(px));
      dy = longint'($signed(y)) - longint'($signed(py));
      hc = $signed(h);
      hp = $signed(ph);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) dsq = '1;
      else dsq = ax * ax + ay * ay;
      lim_sq = 64'(dist_lim) * 64'(dist_lim);
      thr = (64'(turn_fact) * 64'(dist_lim)) >> 12;
      thr_sq = thr * thr;
      dh = hc - hp;
      if (dh < 0) dh = -dh;
      if (dh > int'(turn_lim) && dsq < thr_sq) begin
        if (hp < hc) m = (hc == 0) ? pmc_pkg::MOT_RIGHT : pmc_pkg::MOT_LEFT;
        else m = (hc == 0) ? pmc_pkg::MOT_LEFT : pmc_pkg::MOT_RIGHT;
      end else if (dsq < lim_sq) begin
        m = pmc_pkg::MOT_STOP;
      end else begin
        dd = heading_of(dy, dx) - hp;
        if (dd < 0) dd = -dd;
        m = (dd > 15441 && dd < 36031 && dsq > lim_sq) ? pmc_pkg::MOT_BACK
                                                       : pmc_pkg::MOT_FWD;
      end
      last_x = x;
      last_y = y;
      last_h = h;
      seen = 1;
      pending.insert(pending.size(), m);
    endfunction

    function void check_label(logic [2:0] got);
      pmc_pkg::motion_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected label %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("motion: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0;
  logic signed [15:0] in_heading = 0;
  logic out_valid, in_ready, cfg_pready;
  logic [2:0] out_motion;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  motion_board board;
  bit sending_done = 0;
  int out_wait = 0;

  pose_motion_classifier dut (.*);

  always #5 clk = ~clk;

  // APB write: setup then access
  task automatic write_reg(logic [1:0] idx, bit [31:0] v);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, v);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // one pose transfer, with a random gap before it if gaps is set; valid stays up
  // between back-to-back transfers
  task automatic send_pose(bit [31:0] x, bit [31:0] y, bit [15:0] h, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_heading <= h;
    do @(posedge clk); while (!in_ready);
    board.note_sample(x, y, h);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // result side: after each transfer ready may drop for a random wait, none once sending is done
  always @(posedge clk) begin : result_side
    int draw;
    if (!rst_n) begin
      out_ready <= 0;
      out_wait <= $urandom_range(0, 8);
    end else if (out_valid && out_ready) begin
      board.check_label(out_motion);
      draw = sending_done ? 0 : $urandom_range(0, 8);
      out_wait <= draw;
      out_ready <= (draw == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1;
    end
  end

  // random walk: mostly small steps near the thresholds, some wild jumps
  task automatic random_phase(int n, bit gaps);
    bit [31:0] x, y;
    bit [15:0] h;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      x = board.last_x;
      y = board.last_y;
      h = board.last_h;
      if (kind < 6) begin
        x = x + 32'($signed($urandom_range(0, 2400)) - 1200);
        y = y + 32'($signed($urandom_range(0, 2400)) - 1200);
        h = 16'($urandom_range(0, 51472)) - 16'd25736;
        if (kind < 2) h = board.last_h + 16'($urandom_range(0, 600)) - 16'd300;
      end else if (kind < 8) begin
        h = board.last_h + 16'($urandom_range(0, 600)) - 16'd300;
      end else begin
        x = $urandom;
        y = $urandom;
        h = 16'($urandom);
      end
      send_pose(x, y, h, gaps && ($urandom_range(0, 4) != 0));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: first sample, extremes, zero heading swap
    send_pose(32'h1234_5678, 32'h0, 16'd0, 0);
    send_pose(32'h1234_5678, 32'h0, 16'd1000, 0);
    send_pose(32'h1234_5678, 32'h0, 16'd0, 0);
    send_pose(32'h1234_5678, 32'h0, -16'sd1000, 0);
    send_pose(32'h1234_5678, 32'h0, 16'd0, 0);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'd25736, 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, -16'sd25736, 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1);
    send_pose(32'h7FFF_0000, 32'h7FFF_0000, 16'd0, 1);
    send_pose(32'h7FFE_F000, 32'h7FFF_0000, 16'd0, 1);
    send_pose(32'h7FFF_0000, 32'h7FFF_0000, 16'd25736, 1);
    send_pose(32'h7FFF_0000, 32'h7FFF_1000, 16'd0, 1);
    send_pose(32'h7FFF_0000, 32'h7FFE_F000, 16'd12868, 1);
    send_pose(32'h0, 32'h0, 16'hFFFF, 1);
    drain();
    random_phase(300, 1);
    drain();
    write_reg(pmc_pkg::RegDist, 32'd0);
    write_reg(pmc_pkg::RegTurn, 32'd0);
    write_reg(pmc_pkg::RegFact, 32'd0);
    random_phase(200, 1);
    drain();
    write_reg(pmc_pkg::RegDist, 32'd65535);
    write_reg(pmc_pkg::RegTurn, 32'h7FFF);
    write_reg(pmc_pkg::RegFact, 32'd65535);
    random_phase(200, 1);
    drain();
    write_reg(pmc_pkg::RegDist, 32'd1000);
    write_reg(pmc_pkg::RegTurn, 32'd25736);
    write_reg(pmc_pkg::RegFact, 32'd16384);
    random_phase(300, 0);
    drain();
    write_reg(pmc_pkg::RegDist, 32'hFFFF_0400);
    write_reg(pmc_pkg::RegTurn, 32'd200);
    write_reg(pmc_pkg::RegFact, 32'd8192);
    random_phase(700, 1);
    sending_done = 1;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

### pose_motion_classifier.f
rtl/core/pmc_pkg.sv
rtl/core/pmc_front.sv
rtl/core/pmc_queue.sv
rtl/core/pmc_back.sv
rtl/core/pose_motion_classifier.sv
test/pose_motion_classifier_test.sv
